// ----- rtl/core/svq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svq_pkg: shared types and constants for the split virtqueue ring manager
// Operation codes, status codes, result and queue entry types.
// ----------------------------------------------------------------------------
package svq_pkg;

    localparam int QUEUE_DEPTH_DEF = 256;
    localparam int CFG_LOG2_RESET  = 8;

    localparam logic [1:0] KIND_ADD     = 2'd0;
    localparam logic [1:0] KIND_POST    = 2'd1;
    localparam logic [1:0] KIND_REAP    = 2'd2;
    localparam logic [1:0] KIND_REBUILD = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;

    localparam logic [0:0] REG_QSIZE_LOG2 = 1'd0;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] buf_addr;
        logic [31:0] buf_len;
        logic [15:0] buf_flags;
        logic [7:0]  used_id;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  desc_index;
        logic [8:0]  free_count;
        logic [15:0] ring_index;
    } result_t;

endpackage

// ----- rtl/core/svq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module svq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/svq_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svq_front: input beat capture and two-entry queue toward the back end
// Accepts items and holds them until the back end takes them.
// ----------------------------------------------------------------------------
module svq_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  svq_pkg::item_t  in_item,
    output logic            q_valid,
    input  logic            q_ready,
    output svq_pkg::item_t  q_item
);

    svq_pkg::item_t ent_reg [2];
    logic [1:0]     cnt_reg;
    logic           rd_reg;
    logic           wr_reg;
    logic           push;
    logic           pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = ent_reg[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// ----- rtl/core/svq_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svq_back: operation sequencer over descriptor and ring memories
// Executes add, post, reap and rebuild; drives the result register.
// ----------------------------------------------------------------------------
module svq_back #(
    parameter int QUEUE_DEPTH = svq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [3:0]      qsize_log2,
    input  logic            q_valid,
    output logic            q_ready,
    input  svq_pkg::item_t  q_item,
    output logic            out_valid,
    input  logic            out_ready,
    output svq_pkg::result_t out_res
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int LW = AW + 1;
    localparam logic [LW-1:0] LINK_END = LW'(QUEUE_DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_CLEAR = 3'd2;
    localparam logic [2:0] S_REBLD = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]       state_reg, state_next;
    svq_pkg::item_t   item_reg;
    logic [15:0]      avail_reg, avail_next;
    logic [15:0]      used_reg, used_next;
    logic [15:0]      cons_reg, cons_next;
    logic [LW-1:0]    head_reg, head_next;
    logic [LW-1:0]    total_reg, total_next;
    logic [AW-1:0]    sweep_reg, sweep_next;
    svq_pkg::result_t res_reg, res_next;

    logic [LW-1:0]    qsize;
    logic [15:0]      qmask;
    logic [AW-1:0]    head_idx;

    logic             link_we, desc_we, avail_we, used_we;
    logic [AW-1:0]    link_waddr, link_raddr;
    logic [LW-1:0]    link_wdata, link_rdata;
    logic [AW-1:0]    avail_waddr, used_waddr, used_raddr;
    logic [7:0]       used_rdata;
    logic [111:0]     desc_rdata;
    logic [7:0]       avail_rdata;
    logic [AW-1:0]    reap_idx;

    always_comb
    begin
        if (int'(qsize_log2) >= AW)
        begin
            qsize = LW'(QUEUE_DEPTH);
        end
        else
        begin
            qsize = LW'(1) << qsize_log2;
        end
    end

    assign qmask    = 16'(qsize - LW'(1));
    assign head_idx = head_reg[AW-1:0];
    assign reap_idx = AW'(used_rdata);

    svq_ram #(.WIDTH(LW), .DEPTH(QUEUE_DEPTH)) u_link (
        .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .raddr(link_raddr), .rdata(link_rdata));

    svq_ram #(.WIDTH(112), .DEPTH(QUEUE_DEPTH)) u_desc (
        .clk(clk), .we(desc_we), .waddr(head_idx),
        .wdata({item_reg.buf_addr, item_reg.buf_len, item_reg.buf_flags}),
        .raddr(head_idx), .rdata(desc_rdata));

    svq_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_avail (
        .clk(clk), .we(avail_we), .waddr(avail_waddr), .wdata(8'(head_idx)),
        .raddr(avail_waddr), .rdata(avail_rdata));

    svq_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_used (
        .clk(clk), .we(used_we), .waddr(used_waddr), .wdata(item_reg.used_id),
        .raddr(used_raddr), .rdata(used_rdata));

    assign avail_waddr = AW'(avail_reg & qmask);
    assign used_waddr  = AW'(used_reg & qmask);
    // read address presented in idle so data is ready in exec
    assign used_raddr  = (state_reg == S_IDLE) ? AW'(cons_reg & qmask) : AW'(cons_reg & qmask);

    assign q_ready   = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_res   = res_reg;

    always_comb
    begin
        state_next = state_reg;
        avail_next = avail_reg;
        used_next  = used_reg;
        cons_next  = cons_reg;
        head_next  = head_reg;
        total_next = total_reg;
        sweep_next = sweep_reg;
        res_next   = res_reg;
        link_we    = 1'b0;
        link_waddr = head_idx;
        link_wdata = LINK_END;
        link_raddr = head_idx;
        desc_we    = 1'b0;
        avail_we   = 1'b0;
        used_we    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_next.status     = svq_pkg::ST_OK;
                res_next.desc_index = 8'd0;
                state_next          = S_OUT;
                case (item_reg.kind)
                    svq_pkg::KIND_ADD:
                    begin
                        if (total_reg == '0 || head_reg >= LINK_END)
                        begin
                            res_next.status = svq_pkg::ST_NO_FREE;
                        end
                        else
                        begin
                            res_next.desc_index = 8'(head_idx);
                            head_next  = link_rdata;
                            total_next = total_reg - LW'(1);
                            desc_we    = 1'b1;
                            link_we    = 1'b1;
                            avail_we   = 1'b1;
                            avail_next = avail_reg + 16'd1;
                        end
                        res_next.ring_index = avail_next;
                    end
                    svq_pkg::KIND_POST:
                    begin
                        res_next.desc_index = item_reg.used_id;
                        used_we   = 1'b1;
                        used_next = used_reg + 16'd1;
                        res_next.ring_index = used_next;
                    end
                    svq_pkg::KIND_REAP:
                    begin
                        if (cons_reg == used_reg)
                        begin
                            res_next.status = svq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            res_next.desc_index = 8'(reap_idx);
                            link_we    = 1'b1;
                            link_waddr = reap_idx;
                            link_wdata = head_reg;
                            head_next  = LW'(reap_idx);
                            if (total_reg < qsize)
                            begin
                                total_next = total_reg + LW'(1);
                            end
                            cons_next = cons_reg + 16'd1;
                        end
                        res_next.ring_index = cons_next;
                    end
                    default:
                    begin
                        sweep_next = '0;
                        state_next = S_REBLD;
                    end
                endcase
                res_next.free_count = 9'(total_next);
            end
            S_REBLD, S_CLEAR:
            begin
                // one link per cycle, last in use holds the end mark;
                // the sweep after reset drops back to idle with no beat
                link_we    = 1'b1;
                link_waddr = sweep_reg;
                if (LW'(sweep_reg) == qsize - LW'(1))
                begin
                    link_wdata = LINK_END;
                    head_next  = '0;
                    total_next = qsize;
                    cons_next  = 16'd0;
                    res_next.ring_index = 16'd0;
                    res_next.free_count = 9'(qsize);
                    state_next = (state_reg == S_CLEAR) ? S_IDLE : S_OUT;
                end
                else
                begin
                    link_wdata = LW'(sweep_reg) + LW'(1);
                    sweep_next = sweep_reg + AW'(1);
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
        begin
            item_reg <= q_item;
        end
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            avail_reg <= 16'd0;
            used_reg  <= 16'd0;
            cons_reg  <= 16'd0;
            head_reg  <= '0;
            total_reg <= '0;
            sweep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            avail_reg <= avail_next;
            used_reg  <= used_next;
            cons_reg  <= cons_next;
            head_reg  <= head_next;
            total_reg <= total_next;
            sweep_reg <= sweep_next;
        end
    end

endmodule

// ----- rtl/core/split_virtqueue_ring_manager.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// split_virtqueue_ring_manager: one split virtqueue with linked free list
// Front end queues operation beats; back end runs them against the
// descriptor, link, avail and used memories.
// ----------------------------------------------------------------------------
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid/in_ready, kind..used_id             | sink
//  out     | out_valid/out_ready, status..ring_index      | source
//  cfg     | APB psel/penable/pwrite/paddr/pwdata/prdata  | slave
//
// Add, post and reap each read memory, execute and then present the
// beat; the registered memory reads put the read ahead of execute.
// Rebuild writes one link per cycle over the queue size, then presents
// its beat. After reset a rebuild sweep runs before the first item
// executes; input beats still queue in the front end. A stalled output
// beat holds the back end while the front queue keeps taking two beats.
// ----------------------------------------------------------------------------
module split_virtqueue_ring_manager #(
    parameter int QUEUE_DEPTH = svq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [63:0] buf_addr,
    input  logic [31:0] buf_len,
    input  logic [15:0] buf_flags,
    input  logic [7:0]  used_id,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  desc_index,
    output logic [8:0]  free_count,
    output logic [15:0] ring_index
);

    logic [3:0]       log2_reg;
    svq_pkg::item_t   in_item;
    svq_pkg::item_t   q_item;
    logic             q_valid;
    logic             q_ready;
    svq_pkg::result_t res;

    assign pready = 1'b1;
    assign prdata = (paddr[1:0] == 2'd0) ? {28'd0, log2_reg} : 32'd0;

    // write the size register on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log2_reg <= 4'(svq_pkg::CFG_LOG2_RESET);
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'd0)
        begin
            log2_reg <= pwdata[3:0];
        end
    end

    assign in_item = '{kind: kind, buf_addr: buf_addr, buf_len: buf_len,
                       buf_flags: buf_flags, used_id: used_id};

    svq_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item));

    svq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .qsize_log2(log2_reg), .q_valid(q_valid),
        .q_ready(q_ready), .q_item(q_item), .out_valid(out_valid),
        .out_ready(out_ready), .out_res(res));

    assign status     = res.status;
    assign desc_index = res.desc_index;
    assign free_count = res.free_count;
    assign ring_index = res.ring_index;

endmodule

// ----- tb/split_virtqueue_ring_manager_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// split_virtqueue_ring_manager_tb: self-checking bench for the ring manager
// Runs directed and random add/post/reap/rebuild beats across several queue
// sizes and compares every result beat with an in-bench prediction.
// ----------------------------------------------------------------------------
module split_virtqueue_ring_manager_tb;
    import svq_pkg::*;

    localparam int DEPTH    = 256;
    localparam int LINK_END = 256;

    typedef struct {
        item_t   op;
        result_t res;
    } op_entry_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  kind;
    logic [63:0] buf_addr;
    logic [31:0] buf_len;
    logic [15:0] buf_flags;
    logic [7:0]  used_id;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [7:0]  desc_index;
    logic [8:0]  free_count;
    logic [15:0] ring_index;

    split_virtqueue_ring_manager u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .buf_addr   (buf_addr),
        .buf_len    (buf_len),
        .buf_flags  (buf_flags),
        .used_id    (used_id),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .desc_index (desc_index),
        .free_count (free_count),
        .ring_index (ring_index)
    );

    // Shadow copy of the queue state, advanced as each beat is generated.
    // Beats are accepted in generation order, so the result worked out here
    // is attached to the beat and moved to the expected queue on acceptance.
    logic [3:0]  sh_log2;
    logic [8:0]  sh_link [DEPTH];
    logic [7:0]  sh_used_slot [DEPTH];
    logic        sh_used_wr [DEPTH];
    logic [15:0] sh_avail_cnt;
    logic [15:0] sh_used_cnt;
    logic [15:0] sh_consumed_cnt;
    logic [8:0]  sh_free_head;
    logic [8:0]  sh_free_total;

    op_entry_t   pend_q[$];
    result_t     expected_q[$];
    logic [7:0]  in_flight_ids[$];

    int          fails;
    int          made_cnt;
    int          accepted_cnt;
    int          checked_cnt;
    int          status_seen [4];
    int          cycle_cnt;
    int          gap_left;
    int          burst_left;
    int          hold_left;
    logic        hold_done;

    // ------------------------------------------------------------------------
    // Queue state prediction
    // ------------------------------------------------------------------------
    function automatic int unsigned ring_size();
        int unsigned s;
        s = 1 << sh_log2;
        if (s > DEPTH)
            s = DEPTH;
        return s;
    endfunction

    function automatic logic [7:0] slot_for(logic [15:0] cnt);
        return 8'((cnt & (ring_size() - 1)) % DEPTH);
    endfunction

    // Relink descriptors below the queue size; links above are left alone.
    function automatic void relink_free_list();
        int unsigned n;
        n = ring_size();
        for (int i = 0; i < n; i++)
            sh_link[i] = 9'(i + 1);
        sh_link[n - 1] = 9'(LINK_END);
        sh_free_head    = '0;
        sh_free_total   = 9'(n);
        sh_consumed_cnt = '0;
    endfunction

    function automatic result_t predict_ring_op(item_t op);
        result_t    r;
        logic [7:0] idx;
        logic [7:0] slot;
        r = '0;
        case (op.kind)
            KIND_ADD:
            begin
                if (sh_free_total == 0 || sh_free_head >= LINK_END)
                    r.status = ST_NO_FREE;
                else
                begin
                    idx           = sh_free_head[7:0];
                    sh_free_head  = sh_link[idx];
                    sh_free_total = sh_free_total - 9'd1;
                    sh_link[idx]  = 9'(LINK_END);
                    sh_avail_cnt  = sh_avail_cnt + 16'd1;
                    r.desc_index  = idx;
                end
                r.ring_index = sh_avail_cnt;
            end
            KIND_POST:
            begin
                slot               = slot_for(sh_used_cnt);
                sh_used_slot[slot] = op.used_id;
                sh_used_wr[slot]   = 1'b1;
                sh_used_cnt        = sh_used_cnt + 16'd1;
                r.desc_index       = op.used_id;
                r.ring_index       = sh_used_cnt;
            end
            KIND_REAP:
            begin
                if (sh_consumed_cnt == sh_used_cnt)
                    r.status = ST_EMPTY;
                else
                begin
                    idx          = sh_used_slot[slot_for(sh_consumed_cnt)];
                    sh_link[idx] = sh_free_head;
                    sh_free_head = {1'b0, idx};
                    if (sh_free_total < ring_size())
                        sh_free_total = sh_free_total + 9'd1;
                    sh_consumed_cnt = sh_consumed_cnt + 16'd1;
                    r.desc_index    = idx;
                end
                r.ring_index = sh_consumed_cnt;
            end
            default:
            begin
                relink_free_list();
                r.ring_index = sh_consumed_cnt;
            end
        endcase
        r.free_count = sh_free_total;
        return r;
    endfunction

    // Build one beat, predict it and queue it for the driver. A reap that
    // would read a used slot never written is turned into a post instead.
    task automatic queue_ring_op(logic [1:0] k, logic [63:0] addr, logic [31:0] len,
                                 logic [15:0] flags, logic [7:0] id);
        op_entry_t e;
        int        pick;
        if (k == KIND_REAP && sh_consumed_cnt != sh_used_cnt
            && !sh_used_wr[slot_for(sh_consumed_cnt)])
            k = KIND_POST;
        e.op.kind      = k;
        e.op.buf_addr  = addr;
        e.op.buf_len   = len;
        e.op.buf_flags = flags;
        e.op.used_id   = id;
        e.res          = predict_ring_op(e.op);
        if (k == KIND_ADD && e.res.status == ST_OK)
            in_flight_ids.push_back(e.res.desc_index);
        if (k == KIND_POST)
        begin
            pick = -1;
            foreach (in_flight_ids[i])
                if (pick < 0 && in_flight_ids[i] == id)
                    pick = i;
            if (pick >= 0)
                in_flight_ids.delete(pick);
        end
        if (k == KIND_REBUILD)
            in_flight_ids.delete();
        pend_q.push_back(e);
        made_cnt++;
    endtask

    task automatic queue_random_op();
        int          w;
        logic [1:0]  k;
        logic [7:0]  id;
        logic [63:0] addr;
        w    = $urandom_range(0, 99);
        addr = {$urandom, $urandom};
        id   = 8'($urandom);
        if (w < 38)
            k = KIND_ADD;
        else if (w < 66)
        begin
            k = KIND_POST;
            // Mostly complete a descriptor that is really out; else noise.
            if (in_flight_ids.size() > 0 && $urandom_range(0, 9) != 0)
                id = in_flight_ids[$urandom_range(0, in_flight_ids.size() - 1)];
        end
        else if (w < 97)
            k = KIND_REAP;
        else
            k = KIND_REBUILD;
        queue_ring_op(k, addr, $urandom, 16'($urandom), id);
    endtask

    // ------------------------------------------------------------------------
    // Configuration writes and phase barriers
    // ------------------------------------------------------------------------
    task automatic write_queue_size(logic [3:0] lg);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 2'(REG_QSIZE_LOG2 * 4);
        pwdata  <= {28'd0, lg};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sh_log2 = lg;
    endtask

    // Hold until every queued beat is accepted and answered, then let the
    // back end settle (a rebuild sweep can still be finishing).
    task automatic wait_drained();
        while (accepted_cnt != made_cnt || expected_q.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Clock, reset and run limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("split_virtqueue_ring_manager test failed");
        $finish;
    end

    always @(posedge clk)
        cycle_cnt <= cycle_cnt + 1;

    // ------------------------------------------------------------------------
    // Driver: bursts of beats separated by random gaps
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            gap_left   <= 0;
            burst_left <= 4;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_q.push_back(pend_q.pop_front().res);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!in_valid || in_ready)
            begin
                // The head of pend_q is the next beat once the accepted one
                // has been popped above.
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pend_q.size() > ((in_valid && in_ready) ? 0 : 0))
                begin
                    in_valid  <= 1'b1;
                    kind      <= pend_q[0].op.kind;
                    buf_addr  <= pend_q[0].op.buf_addr;
                    buf_len   <= pend_q[0].op.buf_len;
                    buf_flags <= pend_q[0].op.buf_flags;
                    used_id   <= pend_q[0].op.used_id;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        // Leave long runs with no gaps now and then.
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: windows of full rate and random stalls, plus one long hold
    // started mid-run while the sender is still offering beats
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (!hold_done && accepted_cnt >= 300)
        begin
            hold_done <= 1'b1;
            hold_left <= 400;
            out_ready <= 1'b0;
        end
        else if ((cycle_cnt / 300) % 3 == 0)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 2) != 0);
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each result beat with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result beat with nothing expected: status %0d index %0d",
                       status, desc_index);
                fails++;
            end
            else
            begin
                want = expected_q.pop_front();
                checked_cnt++;
                status_seen[want.status]++;
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    fails++;
                end
                if (desc_index !== want.desc_index)
                begin
                    $error("desc_index: expected %0d, got %0d", want.desc_index, desc_index);
                    fails++;
                end
                if (free_count !== want.free_count)
                begin
                    $error("free_count: expected %0d, got %0d", want.free_count, free_count);
                    fails++;
                end
                if (ring_index !== want.ring_index)
                begin
                    $error("ring_index: expected %0d, got %0d", want.ring_index, ring_index);
                    fails++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [3:0] sizes [8];
        sizes = '{4'd3, 4'd0, 4'd1, 4'd15, 4'd5, 4'd2, 4'd8, 4'd4};

        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        kind         = KIND_ADD;
        buf_addr     = '0;
        buf_len      = '0;
        buf_flags    = '0;
        used_id      = '0;
        out_ready    = 1'b0;
        fails        = 0;
        made_cnt     = 0;
        accepted_cnt = 0;
        checked_cnt  = 0;
        cycle_cnt    = 0;
        status_seen  = '{0, 0, 0, 0};
        sh_log2      = 4'(CFG_LOG2_RESET);
        sh_avail_cnt = '0;
        sh_used_cnt  = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            sh_used_slot[i] = '0;
            sh_used_wr[i]   = 1'b0;
            sh_link[i]      = '0;
        end
        relink_free_list();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, empty reap, noise post, capped free count.
        queue_ring_op(KIND_ADD, '1, '1, '1, '1);
        queue_ring_op(KIND_ADD, '0, '0, '0, '0);
        queue_ring_op(KIND_REAP, '0, '0, '0, '0);
        queue_ring_op(KIND_POST, '0, '0, '0, 8'd1);
        queue_ring_op(KIND_POST, '1, '1, '1, 8'd255);
        queue_ring_op(KIND_REAP, '0, '0, '0, '0);
        queue_ring_op(KIND_REAP, '0, '0, '0, '0);
        queue_ring_op(KIND_REAP, '0, '0, '0, '0);
        queue_ring_op(KIND_ADD, 64'h8000_0000_0000_0001, 32'h8000_0001, 16'h8001, 8'h80);
        queue_ring_op(KIND_REBUILD, '0, '0, '0, '0);
        wait_drained();

        // Single-entry queue: second add finds no free descriptor.
        write_queue_size(4'd0);
        queue_ring_op(KIND_REBUILD, '0, '0, '0, '0);
        queue_ring_op(KIND_ADD, {$urandom, $urandom}, $urandom, 16'($urandom), '0);
        queue_ring_op(KIND_ADD, {$urandom, $urandom}, $urandom, 16'($urandom), '0);
        queue_ring_op(KIND_POST, '0, '0, '0, 8'd0);
        queue_ring_op(KIND_REAP, '0, '0, '0, '0);
        queue_ring_op(KIND_REAP, '0, '0, '0, '0);
        queue_ring_op(KIND_ADD, '1, '0, '1, '1);
        wait_drained();

        // Oversized log2 saturates to the full depth.
        write_queue_size(4'd15);
        queue_ring_op(KIND_REBUILD, '0, '0, '0, '0);
        queue_ring_op(KIND_ADD, '0, '1, '0, '0);
        queue_ring_op(KIND_POST, '0, '0, '0, 8'd0);
        queue_ring_op(KIND_REAP, '0, '0, '0, '0);
        wait_drained();

        // Random phases; the sender pauses at each size change until drained.
        foreach (sizes[p])
        begin
            write_queue_size(sizes[p]);
            if ($urandom_range(0, 3) != 0)
                queue_ring_op(KIND_REBUILD, '0, '0, '0, '0);
            repeat (76) queue_random_op();
            wait_drained();
        end

        $display("covered %0d beats over %0d size settings: ok %0d, no-free %0d, empty %0d",
                 checked_cnt, 3 + $size(sizes), status_seen[ST_OK],
                 status_seen[ST_NO_FREE], status_seen[ST_EMPTY]);
        if (fails == 0 && expected_q.size() == 0)
            $display("split_virtqueue_ring_manager test passed");
        else
            $display("split_virtqueue_ring_manager test failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/svq_pkg.sv
rtl/core/svq_ram.sv
rtl/core/svq_front.sv
rtl/core/svq_back.sv
rtl/core/split_virtqueue_ring_manager.sv
tb/split_virtqueue_ring_manager_tb.sv
